>>> design/bpt_pkg.sv
// Package for the Bezier patch tessellator: default grid size, Q16 one and operation codes.
// No dependencies.
package bpt_pkg;
  localparam int GRID_SIZE_DEF = 10;
  localparam int ONE_Q16 = 65536;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;
endpackage

>>> design/bpt_if.sv
// Valid/ready channel interfaces for the tessellator.
// Depends on nothing.
interface bpt_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [3:0]  point_index;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic [5:0]  grid_row;
  logic [5:0]  grid_col;
  modport source(output valid, operation, point_index, point_x, point_y, point_z,
                 grid_row, grid_col, input ready);
  modport sink(input valid, operation, point_index, point_x, point_y, point_z,
               grid_row, grid_col, output ready);
endinterface

interface bpt_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic signed [31:0] vertex_z;
  logic [16:0] tex_u;
  logic [16:0] tex_v;
  logic        has_faces;
  logic [11:0] tri_a_first;
  logic [11:0] tri_a_second;
  logic [11:0] tri_a_third;
  logic [11:0] tri_b_first;
  logic [11:0] tri_b_second;
  logic [11:0] tri_b_third;
  modport source(output valid, vertex_x, vertex_y, vertex_z, tex_u, tex_v, has_faces,
                 tri_a_first, tri_a_second, tri_a_third, tri_b_first, tri_b_second,
                 tri_b_third, input ready);
  modport sink(input valid, vertex_x, vertex_y, vertex_z, tex_u, tex_v, has_faces,
               tri_a_first, tri_a_second, tri_a_third, tri_b_first, tri_b_second,
               tri_b_third, output ready);
endinterface

>>> design/bpt_lerp.sv
// Registered fixed-point lerp: a + round((b - a) * p / 65536).
// Uses no package items; one multiplier, two register stages.
module bpt_lerp (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic [16:0]        p,
  output logic signed [31:0] y
);
  logic signed [32:0] diff_r;
  logic signed [31:0] a_r;
  logic [16:0]        p_r;
  logic signed [50:0] prod;
  logic signed [50:0] q;

  assign prod = diff_r * $signed({1'b0, p_r});
  // Round half toward plus infinity, arithmetic shift floors.
  assign q = (prod + 51'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    diff_r <= {b[31], b} - {a[31], a};
    a_r    <= a;
    p_r    <= p;
    y      <= a_r + q[31:0];
  end
endmodule

>>> design/bezier_patch_tessellator_core.sv
// Top level of the bicubic Bezier patch tessellator.
// Depends on bpt_pkg, bpt_if (bpt_in_if, bpt_out_if) and bpt_lerp.
//
// Usage: items arrive on the in_ channel (valid/ready, a transfer happens when
// both are high). A load item (operation 0) writes one control point, three
// words, into a 48-word synchronous memory and gives no result; it keeps the
// block busy until its three words are written. An evaluate item (operation 1)
// names a grid row and column. The block reads the 16 control values of each
// axis one per cycle from memory and feeds one shared registered lerp unit:
// for each axis, four row cubics in the column parameter, then one cubic in
// the row parameter. Each row cubic first reads its four control values, and
// every cubic runs six lerps strictly in sequence, each issued and its result
// waited for from the lerp unit before the next starts. Out-of-range grid
// positions are taken but give no result. The result sits in an output
// register; while the receiver stalls the block holds it and accepts no new
// item. Reset clears control state only; memory contents stay undefined until
// loaded.
module bezier_patch_tessellator_core #(
  parameter int GRID_SIZE = bpt_pkg::GRID_SIZE_DEF
) (
  input  logic clk,
  input  logic rst_n,
  bpt_in_if.sink    in_ch,
  bpt_out_if.source out_ch
);
  localparam int GM1 = GRID_SIZE - 1;
  localparam logic [3:0] S_IDLE = 4'd0, S_LOAD = 4'd1, S_RD = 4'd2, S_LA = 4'd3,
                         S_LW = 4'd4, S_OUT = 4'd5;

  logic [3:0] state_r, state_nxt;
  logic signed [31:0] mem [48];
  logic signed [31:0] rdata_r;
  logic [5:0] waddr;
  logic signed [31:0] wdata;
  logic we;
  logic [5:0] raddr;

  logic [1:0]  ld_cnt_r;
  logic [3:0]  slot_r;
  logic signed [31:0] lx_r, ly_r, lz_r;
  logic [5:0]  row_r, col_r;
  logic [16:0] s_r, t_r;
  logic [1:0]  axis_r;
  logic [2:0]  crow_r;   // 0..3 control rows, 4 = row-direction cubic
  logic [2:0]  rd_cnt_r; // 0..4 reads, counts issued plus landed
  logic [2:0]  lstep_r;  // lerp step 0..5
  logic [1:0]  lw_r;
  logic signed [31:0] w_r [4];
  logic signed [31:0] mid_r [4];
  logic signed [31:0] la, lb, ly;
  logic signed [31:0] vx_r, vy_r, vz_r;
  logic ovalid_r;

  // Round-to-nearest parameter k/(G-1) in Q1.16 through a constant function
  // table over at most 64 entries.
  function automatic logic [16:0] param_q16(input logic [5:0] k);
    logic [16:0] tab [64];
    for (int i = 0; i < 64; i++)
      tab[i] = 17'((i * bpt_pkg::ONE_Q16 + GM1 / 2) / GM1);
    return tab[k];
  endfunction

  // Lerp step index j selects operand pairs: level 0 j=0..2, level 1 3..4, level 2 5.
  always_comb begin
    case (lstep_r)
      3'd0: begin la = w_r[0]; lb = w_r[1]; end
      3'd1: begin la = w_r[1]; lb = w_r[2]; end
      3'd2: begin la = w_r[2]; lb = w_r[3]; end
      3'd3: begin la = w_r[0]; lb = w_r[1]; end
      3'd4: begin la = w_r[1]; lb = w_r[2]; end
      default: begin la = w_r[0]; lb = w_r[1]; end
    endcase
  end

  bpt_lerp u_lerp (.clk(clk), .a(la), .b(lb), .p(crow_r == 3'd4 ? t_r : s_r), .y(ly));

  assign raddr = 6'((crow_r[1:0] * 3'd4 + 4'(rd_cnt_r[1:0])) * 3 + 6'(axis_r));
  assign we = state_r == S_LOAD;
  assign waddr = 6'(slot_r * 3 + 6'(ld_cnt_r));
  assign wdata = ld_cnt_r == 2'd0 ? lx_r : (ld_cnt_r == 2'd1 ? ly_r : lz_r);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign in_ch.ready = state_r == S_IDLE;
  assign out_ch.valid = ovalid_r;
  assign out_ch.vertex_x = vx_r;
  assign out_ch.vertex_y = vy_r;
  assign out_ch.vertex_z = vz_r;
  assign out_ch.tex_u = s_r;
  assign out_ch.tex_v = t_r;

  logic faces;
  logic [11:0] cur, prev;
  assign faces = row_r != 6'd0 && col_r != 6'd0;
  assign cur  = 12'(GRID_SIZE * row_r + col_r);
  assign prev = 12'(GRID_SIZE * (row_r - 6'd1) + col_r);
  assign out_ch.has_faces    = faces;
  assign out_ch.tri_a_first  = faces ? cur - 12'd1 : 12'd0;
  assign out_ch.tri_a_second = faces ? cur : 12'd0;
  assign out_ch.tri_a_third  = faces ? prev : 12'd0;
  assign out_ch.tri_b_first  = faces ? cur - 12'd1 : 12'd0;
  assign out_ch.tri_b_second = faces ? prev : 12'd0;
  assign out_ch.tri_b_third  = faces ? prev - 12'd1 : 12'd0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_ch.valid) begin
        if (in_ch.operation == bpt_pkg::OP_LOAD) state_nxt = S_LOAD;
        else if ({1'b0, in_ch.grid_row} < 7'(GRID_SIZE) &&
                 {1'b0, in_ch.grid_col} < 7'(GRID_SIZE))
          state_nxt = S_RD;
      end
      S_LOAD: if (ld_cnt_r == 2'd2) state_nxt = S_IDLE;
      S_RD:   if (rd_cnt_r == 3'd4) state_nxt = S_LA;
      S_LA:   state_nxt = S_LW;
      S_LW: if (lw_r == 2'd1) begin
        if (lstep_r != 3'd5) state_nxt = S_LA;
        else if (crow_r != 3'd4) state_nxt = (crow_r == 3'd3) ? S_LA : S_RD;
        else if (axis_r != 2'd2) state_nxt = S_RD;
        else state_nxt = S_OUT;
      end
      S_OUT: if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovalid_r <= state_nxt == S_OUT;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        ld_cnt_r <= 2'd0; slot_r <= in_ch.point_index;
        lx_r <= in_ch.point_x; ly_r <= in_ch.point_y; lz_r <= in_ch.point_z;
        row_r <= in_ch.grid_row; col_r <= in_ch.grid_col;
        s_r <= param_q16(in_ch.grid_col); t_r <= param_q16(in_ch.grid_row);
        axis_r <= 2'd0; crow_r <= 3'd0; rd_cnt_r <= 3'd0; lstep_r <= 3'd0; lw_r <= 2'd0;
      end
      S_LOAD: ld_cnt_r <= ld_cnt_r + 2'd1;
      S_RD: begin
        // Read data lands in the cycle after its address; word rd_cnt-1 arrives now.
        if (rd_cnt_r != 3'd0) w_r[rd_cnt_r[1:0] - 2'd1] <= rdata_r;
        rd_cnt_r <= rd_cnt_r + 3'd1;
        lstep_r <= 3'd0;
      end
      S_LA: lw_r <= 2'd0;
      S_LW: begin
        lw_r <= lw_r + 2'd1;
        if (lw_r == 2'd1) begin
          case (lstep_r)
            3'd0, 3'd3, 3'd5: w_r[0] <= ly;
            3'd1, 3'd4: w_r[1] <= ly;
            default: w_r[2] <= ly;
          endcase
          lstep_r <= lstep_r + 3'd1;
          if (lstep_r == 3'd5) begin
            lstep_r <= 3'd0;
            rd_cnt_r <= 3'd0;
            if (crow_r != 3'd4) begin
              mid_r[crow_r[1:0]] <= ly;
              if (crow_r == 3'd3) begin
                w_r[0] <= mid_r[0]; w_r[1] <= mid_r[1]; w_r[2] <= mid_r[2]; w_r[3] <= ly;
              end
              crow_r <= crow_r + 3'd1;
            end else begin
              case (axis_r)
                2'd0: vx_r <= ly;
                2'd1: vy_r <= ly;
                default: vz_r <= ly;
              endcase
              axis_r <= axis_r + 2'd1;
              crow_r <= 3'd0;
            end
          end
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> !in_ch.ready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !out_ch.ready |=> ovalid_r && $stable(vx_r))
    else $error("result dropped under stall");
  a_no_we_eval: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> !ovalid_r) else $error("memory write during result");
`endif
endmodule
